// ===== design/wact_pkg.sv =====
// Shared types and codes for the windowed activity ranking block.
package wact_pkg;

    // Field widths fixed by the item layout
    localparam int ID_W    = 31;
    localparam int CNT_W   = 16;
    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int DATE_W  = YEAR_W + MONTH_W + DAY_W;
    localparam int SIZE_W  = 5;
    localparam int FUNC_W  = 2;
    localparam int POS_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 12;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    // Item function codes
    localparam logic [FUNC_W-1:0] FUNC_DATE   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_CLOSE  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_START_YEAR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_MONTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_END_YEAR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MONTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_END_DAY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_SIZE    = 3'd6;

    // One ranking slot, or one travelling insertion token
    typedef struct packed {
        logic             vld;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] cnt;
    } t_slot;

endpackage

// ===== design/wact_cell.sv =====
// One ranking cell: holds an entry, passes the displaced entry or token onward.
module wact_cell import wact_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_shift,
    input  logic  i_app,
    input  t_slot i_nxt,
    input  t_slot i_car,
    output t_slot o_ent,
    output t_slot o_car
);

    logic             r_occ;
    logic [ID_W-1:0]  r_id;
    logic [CNT_W-1:0] r_cnt;
    logic             r_cv;
    logic [ID_W-1:0]  r_cid;
    logic [CNT_W-1:0] r_ccnt;

    logic             n_occ;
    logic [ID_W-1:0]  n_id;
    logic [CNT_W-1:0] n_cnt;
    logic             n_cv;
    logic [ID_W-1:0]  n_cid;
    logic [CNT_W-1:0] n_ccnt;

    // Shift on report; else swap on strictly larger count, or fill an empty cell
    always_comb begin
        n_occ  = r_occ;
        n_id   = r_id;
        n_cnt  = r_cnt;
        n_cv   = 1'b0;
        n_cid  = i_car.id;
        n_ccnt = i_car.cnt;
        if (i_shift) begin
            n_occ = i_nxt.vld;
            n_id  = i_nxt.id;
            n_cnt = i_nxt.cnt;
        end else if (i_car.vld) begin
            if (r_occ) begin
                n_cv = 1'b1;
                if (i_car.cnt > r_cnt) begin
                    n_id   = i_car.id;
                    n_cnt  = i_car.cnt;
                    n_cid  = r_id;
                    n_ccnt = r_cnt;
                end
            end else if (i_app) begin
                n_occ = 1'b1;
                n_id  = i_car.id;
                n_cnt = i_car.cnt;
            end
        end
    end

    // Hold occupancy and token valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
            r_cv  <= 1'b0;
        end else begin
            r_occ <= n_occ;
            r_cv  <= n_cv;
        end
    end

    // Hold entry and token payload
    always_ff @(posedge i_clk) begin
        r_id   <= n_id;
        r_cnt  <= n_cnt;
        r_cid  <= n_cid;
        r_ccnt <= n_ccnt;
    end

    assign o_ent = '{vld: r_occ, id: r_id, cnt: r_cnt};
    assign o_car = '{vld: r_cv, id: r_cid, cnt: r_ccnt};

endmodule

// ===== design/windowed_activity_top_k.sv =====
// Top level: date window counter, ranking cell chain and report sequencer.
//
//  channel  direction  handshake                   payload
//  in       to block   i_in_valid / o_in_ready     func, user_id, commit date
//  out      from block o_out_valid / i_out_ready   rank_user_id .. last
//  cfg      to block   i_cfg_we                    i_cfg_idx, i_cfg_data
//
// Date and close items are taken one per cycle outside a report. A close launches
// a token that walks the cell chain one cell a cycle; closes may follow each
// other back to back. A report waits until no token is in the chain, then emits
// one entry per cycle while the output is not stalled (one result for an empty list).
// Synchronous active-low reset empties the ranking and clears the count.
// A stalled output holds the report; no input is taken until it completes.
module windowed_activity_top_k import wact_pkg::*; #(
    parameter int TOP_MAX = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [FUNC_W-1:0]     i_func,
    input  logic [ID_W-1:0]       i_user_id,
    input  logic [YEAR_W-1:0]     i_commit_year,
    input  logic [MONTH_W-1:0]    i_commit_month,
    input  logic [DAY_W-1:0]      i_commit_day,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [ID_W-1:0]       o_rank_user_id,
    output logic [CNT_W-1:0]      o_rank_count,
    output logic [POS_W-1:0]      o_rank_position,
    output logic                  o_entry_valid,
    output logic                  o_last
);

    localparam int PW = (TOP_MAX > 16) ? $clog2(TOP_MAX) : POS_W;

    // configuration registers
    logic [YEAR_W-1:0]  r_s_year,  r_e_year;
    logic [MONTH_W-1:0] r_s_month, r_e_month;
    logic [DAY_W-1:0]   r_s_day,   r_e_day;
    logic [SIZE_W-1:0]  r_top_size;

    logic [CNT_W-1:0]   r_cur_cnt;
    logic               r_rep;
    logic [PW-1:0]      r_pos;

    logic               r_out_valid;
    logic [ID_W-1:0]    r_out_id;
    logic [CNT_W-1:0]   r_out_cnt;
    logic [POS_W-1:0]   r_out_pos;
    logic               r_out_ent;
    logic               r_out_last;

    logic               w_acc;
    logic               w_slot;
    logic               w_shift;
    logic               w_busy;
    logic               w_in_win;
    logic [DATE_W-1:0]  w_d, w_s, w_e;
    t_slot              w_head;
    t_slot              w_ent [TOP_MAX];
    t_slot              w_car [TOP_MAX];
    logic [TOP_MAX-1:0] w_occ;
    logic [TOP_MAX-1:0] w_occ_nx;
    logic [TOP_MAX-1:0] w_carv;

    // Accept control: reports wait for the chain to settle
    assign w_busy     = |w_carv;
    assign o_in_ready = !r_rep && ((i_func != FUNC_REPORT) || !w_busy);
    assign w_acc      = i_in_valid && o_in_ready;
    assign w_slot     = !r_out_valid || i_out_ready;
    assign w_shift    = r_rep && w_slot && w_occ[0];
    assign w_occ_nx   = w_occ >> 1;

    // Strict window compare on packed year, month, day
    assign w_d = {i_commit_year, i_commit_month, i_commit_day};
    assign w_s = {r_s_year, r_s_month, r_s_day};
    assign w_e = {r_e_year, r_e_month, r_e_day};
    assign w_in_win = (w_s < w_d) && (w_d < w_e);

    // Token for a closing user enters the head cell
    assign w_head = '{vld: w_acc && (i_func == FUNC_CLOSE), id: i_user_id, cnt: r_cur_cnt};

    // Cell chain
    for (genvar j = 0; j < TOP_MAX; j++) begin : g_cell
        t_slot w_cin;
        t_slot w_nxt;
        logic  w_app;

        if (j == 0) begin : g_first
            assign w_cin = w_head;
        end else begin : g_mid
            assign w_cin = w_car[j-1];
        end

        if (j == TOP_MAX - 1) begin : g_tail
            assign w_nxt = '0;
        end else begin : g_body
            assign w_nxt = w_ent[j+1];
        end

        assign w_app = (32'(r_top_size) > 32'(j));

        wact_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_shift),
            .i_app   (w_app),
            .i_nxt   (w_nxt),
            .i_car   (w_cin),
            .o_ent   (w_ent[j]),
            .o_car   (w_car[j])
        );

        assign w_occ[j]  = w_ent[j].vld;
        assign w_carv[j] = w_car[j].vld;
    end

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_year   <= '0;
            r_s_month  <= '0;
            r_s_day    <= '0;
            r_e_year   <= '1;
            r_e_month  <= '1;
            r_e_day    <= '1;
            r_top_size <= SIZE_W'(10);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_YEAR:  r_s_year   <= i_cfg_data[YEAR_W-1:0];
                CFG_START_MONTH: r_s_month  <= i_cfg_data[MONTH_W-1:0];
                CFG_START_DAY:   r_s_day    <= i_cfg_data[DAY_W-1:0];
                CFG_END_YEAR:    r_e_year   <= i_cfg_data[YEAR_W-1:0];
                CFG_END_MONTH:   r_e_month  <= i_cfg_data[MONTH_W-1:0];
                CFG_END_DAY:     r_e_day    <= i_cfg_data[DAY_W-1:0];
                CFG_TOP_SIZE:    r_top_size <= i_cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // Count in-window commits, saturating; clear on close
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_cnt <= '0;
        end else if (w_acc) begin
            if (i_func == FUNC_CLOSE) begin
                r_cur_cnt <= '0;
            end else if (i_func == FUNC_DATE && w_in_win && r_cur_cnt != COUNT_MAX) begin
                r_cur_cnt <= r_cur_cnt + 1'b1;
            end
        end
    end

    // Sequence the report and advance the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep       <= 1'b0;
            r_pos       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc && i_func == FUNC_REPORT) begin
                r_rep <= 1'b1;
                r_pos <= '0;
            end
            if (r_rep && w_slot) begin
                r_out_valid <= 1'b1;
                r_pos       <= PW'(r_pos + 1'b1);
                if (!w_occ[0] || !w_occ_nx[0]) begin
                    r_rep <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Load result payload from the head cell, or the empty marker
    always_ff @(posedge i_clk) begin
        if (r_rep && w_slot) begin
            if (w_occ[0]) begin
                r_out_id   <= w_ent[0].id;
                r_out_cnt  <= w_ent[0].cnt;
                r_out_pos  <= r_pos[POS_W-1:0];
                r_out_ent  <= 1'b1;
                r_out_last <= !w_occ_nx[0];
            end else begin
                r_out_id   <= '0;
                r_out_cnt  <= '0;
                r_out_pos  <= '0;
                r_out_ent  <= 1'b0;
                r_out_last <= 1'b1;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_rank_user_id  = r_out_id;
    assign o_rank_count    = r_out_cnt;
    assign o_rank_position = r_out_pos;
    assign o_entry_valid   = r_out_ent;
    assign o_last          = r_out_last;

    // Occupied cells always form an unbroken run from the head
    a_occ_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_occ_nx & ~w_occ) == '0)
        else $error("ranking occupancy has a gap");

    // No token may travel while a report shifts the chain
    a_rep_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rep && w_busy))
        else $error("insertion token live during report");

    // An accepted report starts the sequencer
    a_rep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_func == FUNC_REPORT) |=> r_rep)
        else $error("report not started");

    // The empty-list marker is a lone final result at position zero
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_entry_valid) |-> (o_last && o_rank_position == '0))
        else $error("malformed empty report");

endmodule
